@@ hw/rtl/utf8d_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 to 16-bit code point decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CORRUPT  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_BADLEAD  = 2'd3
  } status_t;

  // byte class masks and patterns
  localparam logic [7:0] ASCII_MASK = 8'b1000_0000;
  localparam logic [7:0] LEAD2_MASK = 8'b1110_0000;
  localparam logic [7:0] LEAD2_PAT  = 8'b1100_0000;
  localparam logic [7:0] LEAD3_MASK = 8'b1111_0000;
  localparam logic [7:0] LEAD3_PAT  = 8'b1110_0000;
  localparam logic [7:0] LEAD4_MASK = 8'b1111_1000;
  localparam logic [7:0] LEAD4_PAT  = 8'b1111_0000;
  localparam logic [7:0] CONT_MASK  = 8'b1100_0000;
  localparam logic [7:0] CONT_PAT   = 8'b1000_0000;

  localparam int unsigned PARTIAL_W = 10;
  localparam int unsigned RUNE_W    = 16;
  localparam int unsigned LEN_W     = 3;

  typedef struct packed {
    logic [PARTIAL_W-1:0] partial_bits;
    logic [1:0]           bytes_remaining;
    logic [LEN_W-1:0]     bytes_taken;
  } dec_state_t;

  typedef struct packed {
    logic              emit;
    status_t           status;
    logic [RUNE_W-1:0] rune;
    logic [LEN_W-1:0]  seq_length;
  } dec_result_t;

endpackage

@@ hw/rtl/utf8d_step.sv @@
// ----------------------------------------------------------------------------
// utf8d_step
// One decode step: next sequence state and optional result for one byte.
// ----------------------------------------------------------------------------
module utf8d_step (
  input  utf8d_pkg::dec_state_t  st,
  input  logic [7:0]             data_byte,
  output utf8d_pkg::dec_state_t  st_next,
  output utf8d_pkg::dec_result_t res
);

  logic [utf8d_pkg::LEN_W-1:0]  len;
  logic                         four;
  logic [utf8d_pkg::RUNE_W-1:0] merged;

  assign len    = st.bytes_taken + 3'd1;
  assign four   = ({1'b0, st.bytes_taken} + {2'b00, st.bytes_remaining}) == 4'd4;
  assign merged = {st.partial_bits, data_byte[5:0]};

  always_comb begin
    st_next        = st;
    res.emit       = 1'b0;
    res.status     = utf8d_pkg::ST_OK;
    res.rune       = '0;
    res.seq_length = 3'd1;

    if (st.bytes_remaining == 2'd0) begin
      if ((data_byte & utf8d_pkg::ASCII_MASK) == 8'h00) begin
        res.emit = 1'b1;
        res.rune = {8'h00, data_byte};
      end else if ((data_byte & utf8d_pkg::LEAD2_MASK) == utf8d_pkg::LEAD2_PAT) begin
        st_next.partial_bits    = {5'd0, data_byte[4:0]};
        st_next.bytes_remaining = 2'd1;
        st_next.bytes_taken     = 3'd1;
      end else if ((data_byte & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD3_PAT) begin
        st_next.partial_bits    = {6'd0, data_byte[3:0]};
        st_next.bytes_remaining = 2'd2;
        st_next.bytes_taken     = 3'd1;
      end else if ((data_byte & utf8d_pkg::LEAD4_MASK) == utf8d_pkg::LEAD4_PAT) begin
        // payload of a four-byte sequence is dropped
        st_next.partial_bits    = '0;
        st_next.bytes_remaining = 2'd3;
        st_next.bytes_taken     = 3'd1;
      end else begin
        res.emit   = 1'b1;
        res.status = utf8d_pkg::ST_BADLEAD;
      end
    end else if ((data_byte & utf8d_pkg::CONT_MASK) != utf8d_pkg::CONT_PAT) begin
      st_next        = '0;
      res.emit       = 1'b1;
      res.status     = utf8d_pkg::ST_CORRUPT;
      res.seq_length = len;
    end else if (st.bytes_remaining == 2'd1) begin
      st_next        = '0;
      res.emit       = 1'b1;
      res.seq_length = len;
      if (four) begin
        res.status = utf8d_pkg::ST_OVERFLOW;
      end else begin
        res.rune = merged;
      end
    end else begin
      if (!four) begin
        st_next.partial_bits = merged[utf8d_pkg::PARTIAL_W-1:0];
      end
      st_next.bytes_remaining = st.bytes_remaining - 2'd1;
      st_next.bytes_taken     = len;
    end
  end

endmodule

@@ hw/rtl/utf8_to_ucs2_decoder_core.sv @@
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder_core
// UTF-8 byte stream to 16-bit code point decoder with status per sequence.
// ----------------------------------------------------------------------------
// usage
//   input channel: one byte of the UTF-8 stream per transaction on
//   in_valid / in_ready / data_byte.
//   output channel: one transaction per finished sequence on
//   out_valid / out_ready carrying status, rune and seq_length.
//   a lead byte or a middle continuation byte gives no output transaction.
//   a closing byte's result passes through the input register, decode,
//   then the result register before it is offered on the output channel.
//   throughput: one byte per cycle while no output stall holds the flow,
//   the decode step being a single pass of logic against the sequence state.
//   a full result register that is not taken stalls the input register,
//   and in_ready falls only when both registers hold data.
//   reset empties both registers and returns the decoder to idle; an open
//   sequence is dropped without a result.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] rune,
  output logic [2:0]  seq_length
);

  logic                   s_valid;
  logic [7:0]             s_byte;
  logic                   advance;
  utf8d_pkg::dec_state_t  dec_state;
  utf8d_pkg::dec_state_t  dec_state_next;
  utf8d_pkg::dec_result_t res;
  utf8d_pkg::status_t     status_q;
  logic [15:0]            rune_q;
  logic [2:0]             len_q;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s_valid || advance;

  utf8d_step u_step (
    .st        (dec_state),
    .data_byte (s_byte),
    .st_next   (dec_state_next),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_state <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s_valid && res.emit;
      if (s_valid) begin
        dec_state <= dec_state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s_valid && res.emit) begin
      status_q <= res.status;
      rune_q   <= res.rune;
      len_q    <= res.seq_length;
    end
  end

  assign status     = status_q;
  assign rune       = rune_q;
  assign seq_length = len_q;

`ifndef SYNTH
  // open sequence bookkeeping stays consistent
  a_state_consistent: assert property (@(posedge clk) disable iff (rst)
    ((dec_state.bytes_remaining == 2'd0) == (dec_state.bytes_taken == 3'd0)) &&
    (({1'b0, dec_state.bytes_taken} + {2'b00, dec_state.bytes_remaining}) <= 4'd4))
    else $error("decoder sequence state out of range");

  a_overflow_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status_q == utf8d_pkg::ST_OVERFLOW) |-> (len_q == 3'd4))
    else $error("overflow result without four bytes");

  a_badlead_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status_q == utf8d_pkg::ST_BADLEAD) |-> (len_q == 3'd1))
    else $error("invalid lead result longer than one byte");

  a_error_rune_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status_q != utf8d_pkg::ST_OK) |-> (rune_q == 16'h0000))
    else $error("error result carries a rune");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s_valid && !advance) |=> (s_valid && $stable(s_byte)))
    else $error("input register lost a byte under stall");
`endif

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Byte stream stimulus for utf8_to_ucs2_decoder_core. A scoreboard class
// tracks the decoder's sequence state as each byte is accepted, queues the
// status, rune and length due for every sequence that closes, and checks
// each output transaction against the oldest entry in that queue.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned PHASE_BYTES   = 620;

  typedef struct packed {
    utf8d_pkg::status_t status;
    logic [15:0]        rune;
    logic [2:0]         seq_length;
  } rune_result_t;

  class rune_scoreboard;
    logic [9:0]   partial;
    logic [1:0]   remaining;
    logic [2:0]   taken;
    rune_result_t runes_due [$];
    int unsigned  errors;

    function new();
      partial   = '0;
      remaining = '0;
      taken     = '0;
      errors    = 0;
    endfunction

    function void close_sequence(utf8d_pkg::status_t st, logic [15:0] r, logic [2:0] n);
      rune_result_t res;
      res.status     = st;
      res.rune       = r;
      res.seq_length = n;
      runes_due.push_back(res);
      partial   = '0;
      remaining = '0;
      taken     = '0;
    endfunction

    // advance the sequence state by one accepted byte
    function void take_byte(logic [7:0] b);
      logic [2:0] n;
      logic       four;
      if (remaining == 2'd0) begin
        if ((b & utf8d_pkg::ASCII_MASK) == 8'h00) begin
          close_sequence(utf8d_pkg::ST_OK, {8'h00, b}, 3'd1);
        end else if ((b & utf8d_pkg::LEAD2_MASK) == utf8d_pkg::LEAD2_PAT) begin
          partial   = {5'b0, b[4:0]};
          remaining = 2'd1;
          taken     = 3'd1;
        end else if ((b & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD3_PAT) begin
          partial   = {6'b0, b[3:0]};
          remaining = 2'd2;
          taken     = 3'd1;
        end else if ((b & utf8d_pkg::LEAD4_MASK) == utf8d_pkg::LEAD4_PAT) begin
          partial   = '0;
          remaining = 2'd3;
          taken     = 3'd1;
        end else begin
          close_sequence(utf8d_pkg::ST_BADLEAD, 16'h0000, 3'd1);
        end
      end else begin
        n    = taken + 3'd1;
        four = ({1'b0, taken} + {2'b00, remaining}) == 4'd4;
        if ((b & utf8d_pkg::CONT_MASK) != utf8d_pkg::CONT_PAT) begin
          close_sequence(utf8d_pkg::ST_CORRUPT, 16'h0000, n);
        end else if (remaining == 2'd1) begin
          if (four) close_sequence(utf8d_pkg::ST_OVERFLOW, 16'h0000, n);
          else close_sequence(utf8d_pkg::ST_OK, {partial, b[5:0]}, n);
        end else begin
          // four-byte payload is dropped, so partial stays clear
          if (!four) partial = {partial[3:0], b[5:0]};
          remaining = remaining - 2'd1;
          taken     = n;
        end
      end
    endfunction

    function void flag(string what, logic [15:0] want_val, logic [15:0] got_val);
      errors++;
      $display("%0t: %s expected %0h, actual %0h", $time, what, want_val, got_val);
    endfunction

    function void check_rune(logic [1:0] st, logic [15:0] r, logic [2:0] n);
      rune_result_t want;
      if (runes_due.size() == 0) begin
        errors++;
        $display("%0t: result expected none, actual status %0h rune %0h length %0h",
                 $time, st, r, n);
        return;
      end
      want = runes_due.pop_front();
      if (st !== want.status) flag("status", 16'(want.status), 16'(st));
      if (r !== want.rune) flag("rune", want.rune, r);
      if (n !== want.seq_length) flag("seq_length", 16'(want.seq_length), 16'(n));
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [15:0] rune;
  logic [2:0]  seq_length;

  rune_scoreboard decoder_model = new();

  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 84;
  int unsigned hold_asks     = 0;
  int unsigned bytes_sent    = 0;
  int unsigned quiet_cycles  = 0;

  utf8_to_ucs2_decoder_core uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .rune       (rune),
    .seq_length (seq_length)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // handshakes are sampled mid-cycle, where every signal is settled
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) decoder_model.take_byte(data_byte);
      if (out_valid && out_ready) decoder_model.check_rune(status, rune, seq_length);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // result side: random stalls, plus a long hold-off when asked for
  initial begin : receiver
    int unsigned holds_done;
    int unsigned k;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    bytes_sent++;
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom_range(63))};
  endfunction

  // mostly well-formed sequences, some truncated by a bad byte, some noise
  task automatic send_sequence();
    logic [7:0]  seq [4];
    int unsigned pick;
    int unsigned n;
    int unsigned cut;
    int unsigned i;
    pick = $urandom_range(99);
    for (i = 0; i < 4; i++) seq[i] = cont_byte();
    if (pick < 30) begin
      n = 1;
      seq[0] = 8'($urandom_range(127));
    end else if (pick < 55) begin
      n = 2;
      seq[0] = {3'b110, 5'($urandom_range(31))};
    end else if (pick < 78) begin
      n = 3;
      seq[0] = {4'b1110, 4'($urandom_range(15))};
    end else if (pick < 88) begin
      n = 4;
      seq[0] = {5'b11110, 3'($urandom_range(7))};
    end else begin
      n = 1;
      seq[0] = 8'($urandom_range(255));
    end
    if (n > 1 && $urandom_range(99) < 12) begin
      cut = $urandom_range(n - 1, 1);
      seq[cut] = 8'($urandom_range(255));
      if (seq[cut][7:6] == 2'b10) seq[cut][6] = 1'b1;
      n = cut + 1;
    end
    for (i = 0; i < n; i++) push_byte(seq[i]);
  endtask

  task automatic send_phase();
    int unsigned target;
    target = bytes_sent + PHASE_BYTES;
    while (bytes_sent < target) send_sequence();
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (decoder_model.runes_due.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [7:0] opening [25];
    opening = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'hF8,
                8'hC2, 8'hA9, 8'hDF, 8'hBF,
                8'hE2, 8'h82, 8'hAC, 8'hEF, 8'hBF, 8'hBF,
                8'hF0, 8'h9F, 8'h98, 8'h80,
                8'hC3, 8'h41,
                8'hF7, 8'hBF, 8'hBF, 8'hC0};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[i]) push_byte(opening[i]);
    send_phase();
    wait_results_drained();

    send_idle_pct = 84;
    recv_idle_pct = 18;
    send_phase();
    wait_results_drained();

    // no idling; the receiver stalls for a long stretch so the input backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asks++;
    send_phase();
    wait_results_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (decoder_model.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
